// ----- src/ctwa_pkg.sv -----
`default_nettype none
package ctwa_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam logic [15:0] AGE_MAX = 16'hffff;
    localparam logic [15:0] AGE_LIMIT_RESET = 16'd3600;

    localparam logic [2:0] KIND_FIND = 3'd0;
    localparam logic [2:0] KIND_CREATE = 3'd1;
    localparam logic [2:0] KIND_CLEAR = 3'd2;
    localparam logic [2:0] KIND_MARK = 3'd3;
    localparam logic [2:0] KIND_REMOVE = 3'd4;

    localparam logic [2:0] ST_FOUND = 3'd0;
    localparam logic [2:0] ST_CREATED = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [1:0] ROLE_UNKNOWN = 2'd0;
    localparam logic [1:0] ROLE_A = 2'd1;
    localparam logic [1:0] ROLE_B = 2'd2;

    typedef struct packed {
        logic [31:0] a_addr;
        logic [15:0] a_port;
        logic [31:0] b_addr;
        logic [15:0] b_port;
        logic [1:0]  role;
        logic [15:0] age;
    } entry_t;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_ORD    = 9'b000000010,
        S_ENT    = 9'b000000100,
        S_CHK    = 9'b000001000,
        S_AORD   = 9'b000010000,
        S_AENT   = 9'b000100000,
        S_ACHK   = 9'b001000000,
        S_SLOT   = 9'b010000000,
        S_ROUT   = 9'b100000000
    } state_t;

endpackage
`default_nettype wire

// ----- src/connection_table_with_aging_unit.sv -----
`default_nettype none
// connection table with aging. a word is taken when start is high and busy low;
// one result word follows on done for a single cycle and the receiver cannot
// stall it. entries live in one record memory and one order memory, each read
// through a register, so each walked list position reads the order memory and
// then the record memory: a find passes S_ORD and S_CHK per entry, a miss adds
// S_AORD, S_AENT and S_ACHK per entry for the aging and compaction pass, mark
// server uses S_SLOT, and remove uses S_SLOT and S_ROUT, then compacts the order list.
module connection_table_with_aging_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    input  wire logic [2:0]  kind,
    input  wire logic [31:0] src_ip,
    input  wire logic [15:0] src_port,
    input  wire logic [31:0] dst_ip,
    input  wire logic [15:0] dst_port,
    input  wire logic [5:0]  slot_index,
    output logic             done,
    output logic [2:0]       status,
    output logic [5:0]       slot,
    output logic             source_is_a,
    output logic             source_is_server,
    output logic             role_was_wrong,
    output logic [6:0]       removed_count
);

    localparam int SW = ctwa_pkg::SLOT_W;
    localparam int CW = ctwa_pkg::CNT_W;

    ctwa_pkg::entry_t ent_mem [ctwa_pkg::TABLE_SLOTS];
    logic [SW-1:0]    ord_mem [ctwa_pkg::TABLE_SLOTS];
    ctwa_pkg::entry_t ent_rd;
    logic [SW-1:0]    ord_rd;
    logic             ent_we, ord_we;
    logic [SW-1:0]    ent_wa, ent_ra, ord_wa, ord_ra;
    ctwa_pkg::entry_t ent_wd;
    logic [SW-1:0]    ord_wd;

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_wa] <= ent_wd;
        end
        ent_rd <= ent_mem[ent_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_wa] <= ord_wd;
        end
        ord_rd <= ord_mem[ord_ra];
    end

    ctwa_pkg::state_t  state_reg, state_next;
    logic [ctwa_pkg::TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     wpos_reg, wpos_next;
    logic [SW-1:0]     cur_reg, cur_next;
    logic [15:0]       limit_reg;
    logic [2:0]        kind_reg;
    logic [31:0]       sip_reg, dip_reg;
    logic [15:0]       sport_reg, dport_reg;
    logic [SW-1:0]     sidx_reg;
    logic              done_reg, done_next;
    logic [2:0]        status_reg, status_next;
    logic [5:0]        slot_reg, slot_next;
    logic              srca_reg, srca_next, srv_reg, srv_next, wrong_reg, wrong_next;
    logic [6:0]        rem_reg, rem_next;

    logic              sa, sb, da, db;
    logic [SW-1:0]     free_slot;
    logic              free_any;
    ctwa_pkg::entry_t  upd;
    logic [15:0]       aged;

    assign sa = ent_rd.a_addr == sip_reg && ent_rd.a_port == sport_reg;
    assign sb = ent_rd.b_addr == sip_reg && ent_rd.b_port == sport_reg;
    assign da = ent_rd.a_addr == dip_reg && ent_rd.a_port == dport_reg;
    assign db = ent_rd.b_addr == dip_reg && ent_rd.b_port == dport_reg;
    assign aged = (ent_rd.age < ctwa_pkg::AGE_MAX) ? ent_rd.age + 16'd1 : ent_rd.age;

    always_comb
    begin
        free_slot = '0;
        free_any = 1'b0;
        for (int k = ctwa_pkg::TABLE_SLOTS - 1; k >= 0; k--)
        begin
            if (!valid_reg[k])
            begin
                free_slot = SW'(k);
                free_any = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= ctwa_pkg::AGE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            kind_reg  <= kind;
            sip_reg   <= src_ip;
            sport_reg <= src_port;
            dip_reg   <= dst_ip;
            dport_reg <= dst_port;
            sidx_reg  <= slot_index;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        count_next = count_reg;
        pos_next = pos_reg;
        wpos_next = wpos_reg;
        cur_next = cur_reg;
        done_next = 1'b0;
        status_next = status_reg;
        slot_next = slot_reg;
        srca_next = srca_reg;
        srv_next = srv_reg;
        wrong_next = wrong_reg;
        rem_next = rem_reg;
        ent_we = 1'b0;
        ent_wa = cur_reg;
        ent_wd = ent_rd;
        ent_ra = cur_reg;
        ord_we = 1'b0;
        ord_wa = wpos_reg[SW-1:0];
        ord_wd = cur_reg;
        ord_ra = pos_reg[SW-1:0];
        upd = ent_rd;
        case (state_reg)
            ctwa_pkg::S_IDLE:
            begin
                if (start && !busy)
                begin
                    status_next = ctwa_pkg::ST_NOT_FOUND;
                    slot_next = '0;
                    srca_next = 1'b0;
                    srv_next = 1'b0;
                    wrong_next = 1'b0;
                    rem_next = '0;
                    pos_next = '0;
                    wpos_next = '0;
                    ord_ra = '0;
                    cur_next = slot_index;
                    ent_ra = slot_index;
                    if (kind <= ctwa_pkg::KIND_CLEAR)
                    begin
                        state_next = (count_reg == '0) ? ctwa_pkg::S_AORD : ctwa_pkg::S_ORD;
                    end
                    else if ((kind == ctwa_pkg::KIND_MARK || kind == ctwa_pkg::KIND_REMOVE)
                             && valid_reg[slot_index])
                    begin
                        state_next = ctwa_pkg::S_SLOT;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            ctwa_pkg::S_ORD:
            begin
                cur_next = ord_rd;
                ent_ra = ord_rd;
                state_next = ctwa_pkg::S_CHK;
            end
            ctwa_pkg::S_CHK:
            begin
                ent_we = 1'b1;
                if ((sa && db) || (da && sb))
                begin
                    upd.age = '0;
                    if (kind_reg == ctwa_pkg::KIND_CLEAR)
                    begin
                        upd.role = ctwa_pkg::ROLE_UNKNOWN;
                    end
                    ent_wd = upd;
                    status_next = ctwa_pkg::ST_FOUND;
                    slot_next = 6'(cur_reg);
                    srca_next = sa;
                    srv_next = sa ? (upd.role == ctwa_pkg::ROLE_A)
                                  : (upd.role == ctwa_pkg::ROLE_B);
                    done_next = 1'b1;
                    state_next = ctwa_pkg::S_IDLE;
                end
                else
                begin
                    upd.age = aged;
                    ent_wd = upd;
                    pos_next = pos_reg + CW'(1);
                    ord_ra = pos_next[SW-1:0];
                    if (pos_next == count_reg)
                    begin
                        pos_next = '0;
                        ord_ra = '0;
                        state_next = ctwa_pkg::S_AORD;
                    end
                    else
                    begin
                        state_next = ctwa_pkg::S_ORD;
                    end
                end
            end
            ctwa_pkg::S_AORD:
            begin
                if (pos_reg == count_reg)
                begin
                    count_next = wpos_reg;
                    done_next = 1'b1;
                    state_next = ctwa_pkg::S_IDLE;
                    if (kind_reg == ctwa_pkg::KIND_CREATE)
                    begin
                        if (!free_any)
                        begin
                            status_next = ctwa_pkg::ST_FULL;
                        end
                        else
                        begin
                            ent_we = 1'b1;
                            ent_wa = free_slot;
                            ent_wd.a_addr = sip_reg;
                            ent_wd.a_port = sport_reg;
                            ent_wd.b_addr = dip_reg;
                            ent_wd.b_port = dport_reg;
                            ent_wd.role = ctwa_pkg::ROLE_UNKNOWN;
                            ent_wd.age = '0;
                            ord_we = 1'b1;
                            ord_wd = free_slot;
                            valid_next[free_slot] = 1'b1;
                            count_next = wpos_reg + CW'(1);
                            status_next = ctwa_pkg::ST_CREATED;
                            slot_next = 6'(free_slot);
                            srca_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    state_next = ctwa_pkg::S_AENT;
                end
            end
            ctwa_pkg::S_AENT:
            begin
                cur_next = ord_rd;
                ent_ra = ord_rd;
                state_next = ctwa_pkg::S_ACHK;
            end
            ctwa_pkg::S_ACHK:
            begin
                pos_next = pos_reg + CW'(1);
                ord_ra = pos_next[SW-1:0];
                state_next = ctwa_pkg::S_AORD;
                if (kind_reg == ctwa_pkg::KIND_REMOVE ? (cur_reg == sidx_reg)
                                                      : (ent_rd.age >= limit_reg))
                begin
                    valid_next[cur_reg] = 1'b0;
                    if (kind_reg != ctwa_pkg::KIND_REMOVE)
                    begin
                        rem_next = rem_reg + 7'd1;
                    end
                end
                else
                begin
                    ord_we = 1'b1;
                    wpos_next = wpos_reg + CW'(1);
                end
            end
            ctwa_pkg::S_SLOT:
            begin
                status_next = ctwa_pkg::ST_DONE;
                slot_next = 6'(sidx_reg);
                if (kind_reg == ctwa_pkg::KIND_MARK)
                begin
                    ent_we = 1'b1;
                    if (sa)
                    begin
                        wrong_next = ent_rd.role == ctwa_pkg::ROLE_B;
                        upd.role = ctwa_pkg::ROLE_A;
                    end
                    else
                    begin
                        wrong_next = ent_rd.role == ctwa_pkg::ROLE_A;
                        upd.role = ctwa_pkg::ROLE_B;
                    end
                    ent_wd = upd;
                    done_next = 1'b1;
                    state_next = ctwa_pkg::S_IDLE;
                end
                else
                begin
                    state_next = ctwa_pkg::S_ROUT;
                end
            end
            ctwa_pkg::S_ROUT:
            begin
                state_next = ctwa_pkg::S_AORD;
            end
            default:
            begin
                state_next = ctwa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctwa_pkg::S_IDLE;
            valid_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        wpos_reg   <= wpos_next;
        cur_reg    <= cur_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        srca_reg   <= srca_next;
        srv_reg    <= srv_next;
        wrong_reg  <= wrong_next;
        rem_reg    <= rem_next;
    end

    assign busy = state_reg != ctwa_pkg::S_IDLE || done_reg;
    assign done = done_reg;
    assign status = status_reg;
    assign slot = slot_reg;
    assign source_is_a = srca_reg;
    assign source_is_server = srv_reg;
    assign role_was_wrong = wrong_reg;
    assign removed_count = rem_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ctwa_pkg::TABLE_SLOTS))
        else $error("entry count over table size");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held two cycles");
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ctwa_pkg::S_IDLE |-> 32'($countones(valid_reg)) == 32'(count_reg))
        else $error("valid bits disagree with entry count");
    a_created_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == ctwa_pkg::ST_CREATED |-> srca_reg && !srv_reg)
        else $error("created result fields wrong");
`endif

endmodule
`default_nettype wire

// ----- dv/connection_table_with_aging_checker.sv -----
`default_nettype none
module connection_table_with_aging_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    input  wire logic [2:0]  kind,
    input  wire logic [31:0] src_ip,
    input  wire logic [15:0] src_port,
    input  wire logic [31:0] dst_ip,
    input  wire logic [15:0] dst_port,
    input  wire logic [5:0]  slot_index,
    input  wire logic        done,
    input  wire logic [2:0]  status,
    input  wire logic [5:0]  slot,
    input  wire logic        source_is_a,
    input  wire logic        source_is_server,
    input  wire logic        role_was_wrong,
    input  wire logic [6:0]  removed_count,
    output int               error_count,
    output int               pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] slot;
        logic       src_a;
        logic       src_srv;
        logic       wrong;
        logic [6:0] removed;
    } answer_t;

    logic [15:0]      limit_q;
    logic             live [ctwa_pkg::TABLE_SLOTS];
    ctwa_pkg::entry_t tbl [ctwa_pkg::TABLE_SLOTS];
    logic [5:0]       order [ctwa_pkg::TABLE_SLOTS];
    int               used;
    answer_t          answers [$];

    function automatic logic hits_a(int s, logic [31:0] ip, logic [15:0] port);
        return tbl[s].a_addr == ip && tbl[s].a_port == port;
    endfunction

    function automatic logic hits_b(int s, logic [31:0] ip, logic [15:0] port);
        return tbl[s].b_addr == ip && tbl[s].b_port == port;
    endfunction

    function automatic answer_t lookup_update(logic [2:0] k, logic [31:0] sip,
            logic [15:0] sp, logic [31:0] dip, logic [15:0] dp, logic [5:0] idx);
        answer_t r;
        logic hit;
        int s;
        int j;
        r = '0;
        r.status = ctwa_pkg::ST_NOT_FOUND;
        hit = 1'b0;
        if (k == ctwa_pkg::KIND_FIND || k == ctwa_pkg::KIND_CREATE ||
            k == ctwa_pkg::KIND_CLEAR) begin
            for (int i = 0; i < used; i++) begin
                s = order[i];
                if ((hits_a(s, sip, sp) && hits_b(s, dip, dp)) ||
                    (hits_a(s, dip, dp) && hits_b(s, sip, sp))) begin
                    tbl[s].age = '0;
                    if (k == ctwa_pkg::KIND_CLEAR)
                        tbl[s].role = ctwa_pkg::ROLE_UNKNOWN;
                    hit = 1'b1;
                    r.status = ctwa_pkg::ST_FOUND;
                    r.slot = 6'(s);
                    if (hits_a(s, sip, sp)) begin
                        r.src_a = 1'b1;
                        r.src_srv = tbl[s].role == ctwa_pkg::ROLE_A;
                    end
                    else
                        r.src_srv = tbl[s].role == ctwa_pkg::ROLE_B;
                    break;
                end
                if (tbl[s].age != ctwa_pkg::AGE_MAX)
                    tbl[s].age++;
            end
            if (!hit) begin
                j = 0;
                for (int i = 0; i < used; i++) begin
                    s = order[i];
                    if (tbl[s].age >= limit_q) begin
                        live[s] = 1'b0;
                        r.removed++;
                    end
                    else begin
                        order[j] = 6'(s);
                        j++;
                    end
                end
                used = j;
                if (k == ctwa_pkg::KIND_CREATE) begin
                    r.status = ctwa_pkg::ST_FULL;
                    for (s = 0; s < ctwa_pkg::TABLE_SLOTS; s++)
                        if (!live[s])
                            break;
                    if (used < ctwa_pkg::TABLE_SLOTS && s < ctwa_pkg::TABLE_SLOTS) begin
                        live[s] = 1'b1;
                        tbl[s] = {sip, sp, dip, dp, ctwa_pkg::ROLE_UNKNOWN, 16'd0};
                        order[used] = 6'(s);
                        used++;
                        r.status = ctwa_pkg::ST_CREATED;
                        r.slot = 6'(s);
                        r.src_a = 1'b1;
                    end
                end
            end
        end
        else if ((k == ctwa_pkg::KIND_MARK || k == ctwa_pkg::KIND_REMOVE) && live[idx]) begin
            r.status = ctwa_pkg::ST_DONE;
            r.slot = idx;
            if (k == ctwa_pkg::KIND_MARK) begin
                if (hits_a(int'(idx), sip, sp)) begin
                    r.wrong = tbl[idx].role == ctwa_pkg::ROLE_B;
                    tbl[idx].role = ctwa_pkg::ROLE_A;
                end
                else begin
                    r.wrong = tbl[idx].role == ctwa_pkg::ROLE_A;
                    tbl[idx].role = ctwa_pkg::ROLE_B;
                end
            end
            else begin
                j = 0;
                for (int i = 0; i < used; i++)
                    if (order[i] != idx) begin
                        order[j] = order[i];
                        j++;
                    end
                used = j;
                live[idx] = 1'b0;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        answer_t got;
        answer_t want;
        if (!rst_n) begin
            limit_q = ctwa_pkg::AGE_LIMIT_RESET;
            for (int i = 0; i < ctwa_pkg::TABLE_SLOTS; i++)
                live[i] = 1'b0;
            used = 0;
            answers.delete();
            error_count = 0;
            pending_count = 0;
        end
        else begin
            if (done) begin
                got = {status, slot, source_is_a, source_is_server, role_was_wrong,
                       removed_count};
                if (answers.size() == 0) begin
                    $error("result word with nothing expected");
                    error_count++;
                end
                else begin
                    want = answers.pop_front();
                    if (got.status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, got.status);
                        error_count++;
                    end
                    if (got.slot !== want.slot) begin
                        $error("slot exp %0d got %0d", want.slot, got.slot);
                        error_count++;
                    end
                    if (got.src_a !== want.src_a) begin
                        $error("source_is_a exp %0d got %0d", want.src_a, got.src_a);
                        error_count++;
                    end
                    if (got.src_srv !== want.src_srv) begin
                        $error("source_is_server exp %0d got %0d", want.src_srv,
                               got.src_srv);
                        error_count++;
                    end
                    if (got.wrong !== want.wrong) begin
                        $error("role_was_wrong exp %0d got %0d", want.wrong, got.wrong);
                        error_count++;
                    end
                    if (got.removed !== want.removed) begin
                        $error("removed_count exp %0d got %0d", want.removed,
                               got.removed);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
                answers.push_back(lookup_update(kind, src_ip, src_port, dst_ip,
                                                dst_port, slot_index));
            if (cfg_we)
                limit_q = cfg_data;
            pending_count = answers.size();
        end
    end
endmodule
`default_nettype wire

// ----- dv/connection_table_with_aging_unit_tb.sv -----
`default_nettype none
module connection_table_with_aging_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cfg_we;
    logic [15:0] cfg_data;
    logic [2:0]  kind;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [31:0] dst_ip;
    logic [15:0] dst_port;
    logic [5:0]  slot_index;
    logic        done;
    logic [2:0]  status;
    logic [5:0]  slot;
    logic        source_is_a;
    logic        source_is_server;
    logic        role_was_wrong;
    logic [6:0]  removed_count;
    int          error_count;
    int          pending_count;

    logic [31:0] pool_ip [8];
    logic [15:0] pool_port [8];
    int          gap_pct;

    connection_table_with_aging_unit DUT (.*);
    connection_table_with_aging_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #8000000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_word(logic [2:0] k, logic [31:0] sip, logic [15:0] sp,
            logic [31:0] dip, logic [15:0] dp, logic [5:0] idx);
        while ($urandom_range(99) < gap_pct)
            @(posedge clk);
        start <= 1'b1;
        kind <= k;
        src_ip <= sip;
        src_port <= sp;
        dst_ip <= dip;
        dst_port <= dp;
        slot_index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending_count != 0 || busy)
            @(posedge clk);
        repeat (400)
            @(posedge clk);
    endtask

    task automatic write_limit(logic [15:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_word();
        int a;
        int b;
        int r;
        logic [2:0] k;
        a = $urandom_range(7);
        b = $urandom_range(7);
        r = $urandom_range(99);
        k = r < 30 ? ctwa_pkg::KIND_CREATE : r < 55 ? ctwa_pkg::KIND_FIND :
            r < 68 ? ctwa_pkg::KIND_CLEAR : r < 85 ? ctwa_pkg::KIND_MARK :
            r < 96 ? ctwa_pkg::KIND_REMOVE : 3'($urandom_range(7));
        if ($urandom_range(9) == 0)
            send_word(k, $urandom, 16'($urandom), $urandom, 16'($urandom),
                      6'($urandom));
        else
            send_word(k, pool_ip[a], pool_port[a], pool_ip[b], pool_port[b],
                      6'($urandom_range(63)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        kind = '0;
        src_ip = '0;
        src_port = '0;
        dst_ip = '0;
        dst_port = '0;
        slot_index = '0;
        gap_pct = 0;
        for (int i = 0; i < 8; i++)
        begin
            pool_ip[i] = $urandom;
            pool_port[i] = 16'($urandom);
        end
        pool_ip[0] = '0;
        pool_port[0] = '0;
        pool_ip[1] = '1;
        pool_port[1] = '1;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_word(ctwa_pkg::KIND_FIND, 0, 0, '1, '1, 0);
        send_word(ctwa_pkg::KIND_CREATE, 0, 0, '1, '1, 0);
        send_word(ctwa_pkg::KIND_FIND, '1, '1, 0, 0, 0);
        send_word(ctwa_pkg::KIND_MARK, '1, '1, 0, 0, 0);
        send_word(ctwa_pkg::KIND_MARK, 0, 0, 0, 0, 0);
        send_word(ctwa_pkg::KIND_FIND, 0, 0, '1, '1, 0);
        send_word(ctwa_pkg::KIND_CLEAR, 0, 0, '1, '1, 0);
        send_word(ctwa_pkg::KIND_MARK, 0, 0, 0, 0, 63);
        send_word(ctwa_pkg::KIND_REMOVE, 0, 0, 0, 0, 63);
        send_word(3'd5, 0, 0, 0, 0, 0);
        send_word(3'd7, '1, '1, '1, '1, 63);
        send_word(ctwa_pkg::KIND_REMOVE, 0, 0, 0, 0, 0);
        send_word(ctwa_pkg::KIND_CREATE, 1, 2, 3, 4, 0);
        send_word(ctwa_pkg::KIND_CREATE, 5, 6, 7, 8, 0);
        write_limit(16'd1);
        send_word(ctwa_pkg::KIND_FIND, 9, 9, 9, 9, 0);
        send_word(ctwa_pkg::KIND_CREATE, 9, 9, 9, 9, 0);
        // fill the table, then overflow
        write_limit(16'hffff);
        for (int i = 0; i < 65; i++)
            send_word(ctwa_pkg::KIND_CREATE, i, 16'(i), 32'hffff_0000, 16'hffff, 0);
        send_word(ctwa_pkg::KIND_FIND, 0, 1, 2, 3, 0);
        write_limit(16'd64);
        send_word(ctwa_pkg::KIND_CREATE, 0, 1, 2, 3, 0);
        write_limit(ctwa_pkg::AGE_LIMIT_RESET);
        for (int i = 0; i < 64; i++)
            send_word(ctwa_pkg::KIND_REMOVE, 0, 0, 0, 0, 6'(i));

        for (int phase = 0; phase < 6; phase++)
        begin
            gap_pct = phase < 2 ? 6 : phase < 4 ? 71 : 0;
            case (phase)
                0: write_limit(16'd1);
                1: write_limit(16'd5);
                2: write_limit(16'd40);
                3: write_limit(16'd3);
                4: write_limit(16'hffff);
                default: write_limit(16'd12);
            endcase
            for (int n = 0; n < 215; n++)
                random_word();
        end

        drain();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ----- connection_table_with_aging_unit.f -----
src/ctwa_pkg.sv
src/connection_table_with_aging_unit.sv
dv/connection_table_with_aging_checker.sv
dv/connection_table_with_aging_unit_tb.sv
